// ===== sv/swpf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpf_pkg
// Shared types, constants and arithmetic helpers of the spherical window
// point filter.
// ----------------------------------------------------------------------------
package swpf_pkg;

  localparam int CoordW  = 32;
  localparam int AngleW  = 16;
  localparam int Stages  = 16;
  localparam int Guard   = 8;
  // Internal datapath width: coordinates plus guard bits plus CORDIC growth.
  localparam int DW      = 44;
  // Internal angle width: 32 fraction-of-turn bits plus sign and headroom.
  localparam int AW      = 35;
  localparam int AngSh   = 32 - AngleW;
  localparam logic [31:0] KGain = 32'd1304065748;

  // Rejection reason codes.
  localparam logic [2:0] RsnKept   = 3'd0;
  localparam logic [2:0] RsnRLow   = 3'd1;
  localparam logic [2:0] RsnRHigh  = 3'd2;
  localparam logic [2:0] RsnAzLow  = 3'd3;
  localparam logic [2:0] RsnAzHigh = 3'd4;
  localparam logic [2:0] RsnElLow  = 3'd5;
  localparam logic [2:0] RsnElHigh = 3'd6;
  localparam logic [2:0] RsnThin   = 3'd7;

  // Register indexes.
  localparam logic [2:0] RegRLow  = 3'd0;
  localparam logic [2:0] RegRHigh = 3'd1;
  localparam logic [2:0] RegAzLow = 3'd2;
  localparam logic [2:0] RegAzHi  = 3'd3;
  localparam logic [2:0] RegElLow = 3'd4;
  localparam logic [2:0] RegElHi  = 3'd5;
  localparam logic [2:0] RegThr   = 3'd6;
  localparam logic [2:0] RegSph   = 3'd7;

  // CORDIC operating mode of one engine.
  typedef enum logic {
    CORDIC_VEC,
    CORDIC_ROT
  } cordic_mode_t;

  // One CORDIC working set.
  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [AW-1:0] a;
  } cordic_vec_t;

  // Side payload carried past the CORDIC engines.
  typedef struct packed {
    logic                 sph;
    logic                 flip;
    logic                 zero_xy;
    logic                 zero_all;
    logic signed [31:0]   x;
    logic signed [31:0]   y;
    logic signed [31:0]   z;
    logic [15:0]          az;
    logic signed [AW-1:0] az_a;
    logic [31:0]          r;
    logic [15:0]          rnd;
    logic signed [15:0]   el;
    logic signed [DW-1:0] zz;
  } side_t;

  // Arctangent of 2^-i in 2^32 turn units.
  function automatic logic signed [AW-1:0] atan_turn(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0: v = 30'd536870912;  5'd1: v = 30'd316933406;
      5'd2: v = 30'd167458907;  5'd3: v = 30'd85004756;
      5'd4: v = 30'd42667331;   5'd5: v = 30'd21354465;
      5'd6: v = 30'd10679838;   5'd7: v = 30'd5340245;
      5'd8: v = 30'd2670163;    5'd9: v = 30'd1335087;
      5'd10: v = 30'd667544;    5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;    5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;     5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;     5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;       5'd21: v = 30'd326;
      5'd22: v = 30'd163;       5'd23: v = 30'd81;
      5'd24: v = 30'd41;        5'd25: v = 30'd20;
      5'd26: v = 30'd10;        5'd27: v = 30'd5;
      5'd28: v = 30'd3;         5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return $signed({{(AW-30){1'b0}}, v});
  endfunction

  // One CORDIC micro-rotation.
  function automatic cordic_vec_t cordic_step(input cordic_vec_t v, input cordic_mode_t m,
                                              input logic [4:0] i);
    cordic_vec_t o;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic pos;
    dx = v.y >>> i;
    dy = v.x >>> i;
    pos = (m == CORDIC_VEC) ? !v.y[DW-1] : !v.a[AW-1];
    if ((m == CORDIC_VEC && pos) || (m == CORDIC_ROT && !pos)) begin
      o.x = v.x + dx;
      o.y = v.y - dy;
    end else begin
      o.x = v.x - dx;
      o.y = v.y + dy;
    end
    if (m == CORDIC_VEC) begin
      o.a = pos ? v.a + atan_turn(i) : v.a - atan_turn(i);
    end else begin
      o.a = pos ? v.a - atan_turn(i) : v.a + atan_turn(i);
    end
    return o;
  endfunction

  // Magnitude of v times K, rounded half up, for |v| < 2^43.
  function automatic logic [75:0] mulk_mag(input logic [DW-1:0] m);
    logic [75:0] ph;
    logic [75:0] pl;
    ph = ({64'd0, m[DW-1:32]} * {44'd0, KGain}) << 1;
    pl = ({44'd0, m[31:0]} * {44'd0, KGain} + 76'd1073741824) >> 31;
    return ph + pl;
  endfunction

endpackage

// ===== sv/swpf_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpf_cordic
// Pipelined CORDIC engine, one micro-rotation per register stage, with
// a valid bit and a side payload travelling alongside.
// ----------------------------------------------------------------------------
module swpf_cordic
  import swpf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  cordic_mode_t             in_mode,
  input  cordic_vec_t              in_vec,
  input  side_t                    in_side,
  output logic                     out_valid,
  output cordic_vec_t              out_vec,
  output side_t                    out_side
);

  logic         vld_r  [Stages];
  cordic_mode_t mode_r [Stages];
  cordic_vec_t  vec_r  [Stages];
  side_t        side_r [Stages];

  // Stage chain; the whole chain advances together when enabled.
  always_ff @(posedge clk) begin
    if (en) begin
      vec_r[0]  <= cordic_step(in_vec, in_mode, 5'd0);
      mode_r[0] <= in_mode;
      side_r[0] <= in_side;
      for (int i = 1; i < Stages; i++) begin
        vec_r[i]  <= cordic_step(vec_r[i-1], mode_r[i-1], 5'(i));
        mode_r[i] <= mode_r[i-1];
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Stages; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < Stages; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  assign out_valid = vld_r[Stages-1];
  assign out_vec   = vec_r[Stages-1];
  assign out_side  = side_r[Stages-1];

endmodule

// ===== sv/spherical_window_point_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spherical_window_point_filter
// Converts points between Cartesian and spherical form and filters them.
// ----------------------------------------------------------------------------
// Usage: points enter on the in_ stream (x,y,z or az,el,r plus a random
// value), one result per point leaves on the out_ stream in order. The APB
// port sets the windows, thinning threshold and input mode; write it only
// while no point is in flight.
// Throughput is one point per clock while the receiver takes results. The pipeline
// has 38 register stages: input decode, two 16-stage CORDIC pipelines with a
// gain stage between them, a second gain stage, rounding, window tests and
// the output register.
// The whole pipeline advances when the output register is empty or taken;
// when the receiver stalls a full pipeline holds and in_tready drops, so
// nothing is lost or repeated.
// Reset clears valid bits, the kept count and loads the register defaults.
// ----------------------------------------------------------------------------
module spherical_window_point_filter
  import swpf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] in_x_or_az, [63:32] in_y_or_el, [95:64] in_z_or_r, [111:96] random_value
  input  logic [111:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] kept, [3:1] reason, [35:4] out_x, [67:36] out_y, [99:68] out_z,
  // [115:100] out_az, [131:116] out_el, [163:132] out_r, [195:164] kept_total
  output logic [199:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  // Configuration registers.
  logic [31:0] r_low_r, r_high_r;
  logic [15:0] az_low_r, az_high_r, el_low_r, el_high_r, thr_r;
  logic        sph_r;
  logic        cfg_we;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_we  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_low_r <= '0; r_high_r <= 32'd19660800; az_low_r <= '0; az_high_r <= '0;
      el_low_r <= '0; el_high_r <= '0; thr_r <= 16'hFFFF; sph_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegRLow:  r_low_r   <= cfg_pwdata;
        RegRHigh: r_high_r  <= cfg_pwdata;
        RegAzLow: az_low_r  <= cfg_pwdata[15:0];
        RegAzHi:  az_high_r <= cfg_pwdata[15:0];
        RegElLow: el_low_r  <= cfg_pwdata[15:0];
        RegElHi:  el_high_r <= cfg_pwdata[15:0];
        RegThr:   thr_r     <= cfg_pwdata[15:0];
        RegSph:   sph_r     <= cfg_pwdata[0];
        default:  ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_idx)
      RegRLow:  cfg_prdata = r_low_r;
      RegRHigh: cfg_prdata = r_high_r;
      RegAzLow: cfg_prdata = {16'd0, az_low_r};
      RegAzHi:  cfg_prdata = {16'd0, az_high_r};
      RegElLow: cfg_prdata = {16'd0, el_low_r};
      RegElHi:  cfg_prdata = {16'd0, el_high_r};
      RegThr:   cfg_prdata = {16'd0, thr_r};
      RegSph:   cfg_prdata = {31'd0, sph_r};
      default:  cfg_prdata = '0;
    endcase
  end

  // Global advance: the pipeline moves when the output register can load.
  logic en;
  logic o_vld_r;
  assign en         = !o_vld_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = o_vld_r;

  // ---------------- Stage A: input decode and pre-scaling ----------------
  logic               a_vld_r;
  cordic_mode_t       a_mode_r;
  cordic_vec_t        a_vec_r;
  side_t              a_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (en) a_vld_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    logic signed [31:0] ix, iy, iz;
    logic signed [31:0] elc;
    logic signed [31:0] rs;
    logic signed [DW-1:0] xs, ys;
    logic signed [AW-1:0] aa;
    logic [75:0] km;
    logic fl;
    if (en) begin
      ix = in_tdata[31:0]; iy = in_tdata[63:32]; iz = in_tdata[95:64];
      a_side_r.rnd <= in_tdata[111:96];
      a_side_r.sph <= sph_r;
      a_side_r.zz  <= '0;
      if (sph_r) begin
        elc = iy;
        if (elc > 32'sd16384) elc = 32'sd16384;
        if (elc < -32'sd16384) elc = -32'sd16384;
        rs = iz[31] ? 32'sd0 : iz;
        km = mulk_mag({4'd0, rs[31:0], 8'd0});
        a_mode_r      <= CORDIC_ROT;
        a_vec_r.x     <= $signed(km[DW-1:0]);
        a_vec_r.y     <= '0;
        a_vec_r.a     <= $signed({{(AW-32){elc[31]}}, elc[15:0], 16'd0});
        // azimuth folded into the right half-plane
        aa = $signed({{(AW-32){ix[15]}}, ix[15:0], 16'd0});
        fl = 1'b0;
        if (aa > $signed(AW'(64'sd1073741824))) begin
          aa = aa - AW'(64'sd2147483648); fl = 1'b1;
        end else if (aa < -$signed(AW'(64'sd1073741824))) begin
          aa = aa + AW'(64'sd2147483648); fl = 1'b1;
        end
        a_side_r.az   <= ix[15:0];
        a_side_r.az_a <= aa;
        a_side_r.flip <= fl;
        a_side_r.r    <= rs;
        a_side_r.el   <= elc[15:0];
        a_side_r.x <= '0; a_side_r.y <= '0; a_side_r.z <= '0;
        a_side_r.zero_xy <= 1'b0; a_side_r.zero_all <= 1'b0;
      end else begin
        xs = {{(DW-40){ix[31]}}, ix, 8'd0};
        ys = {{(DW-40){iy[31]}}, iy, 8'd0};
        fl = ix[31];
        a_mode_r  <= CORDIC_VEC;
        a_vec_r.x <= fl ? -xs : xs;
        a_vec_r.y <= fl ? -ys : ys;
        a_vec_r.a <= fl ? AW'(64'sd2147483648) : '0;
        a_side_r.flip <= fl;
        a_side_r.x <= ix; a_side_r.y <= iy; a_side_r.z <= iz;
        a_side_r.zero_xy  <= (ix == 0) && (iy == 0);
        a_side_r.zero_all <= (ix == 0) && (iy == 0) && (iz == 0);
        a_side_r.az <= '0; a_side_r.az_a <= '0; a_side_r.r <= '0;
        a_side_r.el <= '0;
      end
    end
  end

  // ---------------- First CORDIC ----------------
  logic        c1_vld;
  cordic_vec_t c1_vec;
  side_t       c1_side;

  swpf_cordic u_cordic1 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(a_vld_r), .in_mode(a_mode_r), .in_vec(a_vec_r), .in_side(a_side_r),
    .out_valid(c1_vld), .out_vec(c1_vec), .out_side(c1_side)
  );

  // ---------------- Stage B: gain and second CORDIC setup ----------------
  logic         b_vld_r;
  cordic_mode_t b_mode_r;
  cordic_vec_t  b_vec_r;
  side_t        b_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else if (en) b_vld_r <= c1_vld;
  end

  always_ff @(posedge clk) begin
    logic [DW-1:0] m;
    logic [75:0] km;
    logic signed [DW-1:0] kv;
    logic [15:0] azr;
    logic [31:0] au;
    side_t sd;
    if (en) begin
      m  = c1_vec.x[DW-1] ? DW'(-c1_vec.x) : c1_vec.x;
      km = mulk_mag(m);
      kv = c1_vec.x[DW-1] ? -$signed(km[DW-1:0]) : $signed(km[DW-1:0]);
      au  = c1_vec.a[31:0] + 32'd32768;
      azr = c1_side.zero_xy ? 16'd0 : au[31:16];
      sd = c1_side;
      sd.zz = c1_vec.y;
      if (c1_side.sph) begin
        b_mode_r  <= CORDIC_ROT;
        b_vec_r.x <= kv;
        b_vec_r.y <= '0;
        b_vec_r.a <= c1_side.az_a;
      end else begin
        sd.az = azr;
        b_mode_r  <= CORDIC_VEC;
        b_vec_r.x <= c1_side.zero_xy ? '0 : kv;
        b_vec_r.y <= {{(DW-40){c1_side.z[31]}}, c1_side.z, 8'd0};
        b_vec_r.a <= '0;
      end
      b_side_r <= sd;
    end
  end

  // ---------------- Second CORDIC ----------------
  logic        c2_vld;
  cordic_vec_t c2_vec;
  side_t       c2_side;

  swpf_cordic u_cordic2 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(b_vld_r), .in_mode(b_mode_r), .in_vec(b_vec_r), .in_side(b_side_r),
    .out_valid(c2_vld), .out_vec(c2_vec), .out_side(c2_side)
  );

  // ---------------- Stage C: gain on Cartesian radius ----------------
  logic        d_vld_r;
  side_t       d_side_r;
  cordic_vec_t d_vec_r;
  logic signed [DW-1:0] d_kx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d_vld_r <= 1'b0;
    else if (en) d_vld_r <= c2_vld;
  end

  always_ff @(posedge clk) begin
    logic [DW-1:0] m;
    logic [75:0] km;
    if (en) begin
      m  = c2_vec.x[DW-1] ? DW'(-c2_vec.x) : c2_vec.x;
      km = mulk_mag(m);
      d_kx_r   <= c2_vec.x[DW-1] ? -$signed(km[DW-1:0]) : $signed(km[DW-1:0]);
      d_side_r <= c2_side;
      d_vec_r  <= c2_vec;
    end
  end

  // Round off guard bits and saturate to a signed coordinate.
  function automatic logic signed [31:0] unguard(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] t;
    t = (v + DW'(128)) >>> Guard;
    if (t > DW'(64'sh7FFFFFFF)) return 32'sh7FFFFFFF;
    if (t < -DW'(64'sh80000000)) return 32'sh80000000;
    return t[31:0];
  endfunction

  // ---------------- Stage E: final conversion ----------------
  logic        e_vld_r;
  side_t       e_side_r;
  logic signed [15:0] e_el_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e_vld_r <= 1'b0;
    else if (en) e_vld_r <= d_vld_r;
  end

  always_ff @(posedge clk) begin
    logic signed [AW-1:0] el;
    logic signed [DW-1:0] rr;
    logic signed [DW-1:0] cx, cy;
    side_t sd;
    if (en) begin
      sd = d_side_r;
      if (d_side_r.sph) begin
        cx = d_side_r.flip ? -d_vec_r.x : d_vec_r.x;
        cy = d_side_r.flip ? -d_vec_r.y : d_vec_r.y;
        sd.x = unguard(cx);
        sd.y = unguard(cy);
        sd.z = unguard(d_side_r.zz);
        e_el_r <= d_side_r.el;
      end else begin
        el = (d_vec_r.a + AW'(32768)) >>> AngSh;
        if (el > AW'(16384)) el = AW'(16384);
        if (el < -AW'(16384)) el = -AW'(16384);
        rr = (d_kx_r + DW'(128)) >>> Guard;
        if (rr < 0) rr = '0;
        if (rr > DW'(64'shFFFFFFFF)) rr = DW'(64'shFFFFFFFF);
        e_el_r <= d_side_r.zero_all ? 16'd0 : el[15:0];
        sd.r   = d_side_r.zero_all ? 32'd0 : rr[31:0];
      end
      e_side_r <= sd;
    end
  end

  // ---------------- Stage F: window tests ----------------
  logic        f_vld_r;
  side_t       f_side_r;
  logic signed [15:0] f_el_r;
  logic [2:0]  f_reason_r;

  always_ff @(posedge clk) begin
    if (!rst_n) f_vld_r <= 1'b0;
    else if (en) f_vld_r <= e_vld_r;
  end

  always_ff @(posedge clk) begin
    logic signed [15:0] el;
    logic [2:0] rs;
    if (en) begin
      el = e_el_r;
      if (e_side_r.r < r_low_r) rs = RsnRLow;
      else if (e_side_r.r > r_high_r) rs = RsnRHigh;
      else if (az_low_r != az_high_r && e_side_r.az < az_low_r) rs = RsnAzLow;
      else if (az_low_r != az_high_r && e_side_r.az > az_high_r) rs = RsnAzHigh;
      else if (el_low_r != el_high_r && el < $signed(el_low_r)) rs = RsnElLow;
      else if (el_low_r != el_high_r && el > $signed(el_high_r)) rs = RsnElHigh;
      else if (e_side_r.rnd > thr_r) rs = RsnThin;
      else rs = RsnKept;
      f_reason_r <= rs;
      f_side_r   <= e_side_r;
      f_el_r     <= el;
    end
  end

  // ---------------- Output register and kept count ----------------
  logic [31:0] cnt_r;
  logic [31:0] cnt_nxt;
  logic        kp;
  assign kp      = (f_reason_r == RsnKept);
  assign cnt_nxt = cnt_r + 32'(kp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
      cnt_r   <= '0;
    end else if (en) begin
      o_vld_r <= f_vld_r;
      if (f_vld_r) cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata <= {4'd0, cnt_nxt, f_side_r.r, f_el_r, f_side_r.az,
                    f_side_r.z, f_side_r.y, f_side_r.x, f_reason_r, kp};
    end
  end

endmodule

// ===== bench/swpf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpf_checker
// Watches the point and result streams of the spherical window point filter,
// predicts each result from the accepted point and the current register
// settings, and compares every field of the result against the prediction.
// ----------------------------------------------------------------------------
module swpf_checker
  import swpf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [111:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [199:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  input  logic         cfg_pready,
  output int           fail_count,
  output int           pending_count,
  output int           result_count
);

  // Expected content of one result transaction, highest field first.
  typedef struct packed {
    logic [31:0] total;
    logic [31:0] r;
    logic [15:0] el;
    logic [15:0] az;
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
    logic [2:0]  reason;
    logic        kept;
  } point_result_t;

  point_result_t expected_results[$];

  // Shadow copy of the filter settings and the kept counter.
  logic [31:0] sh_r_low, sh_r_high;
  logic [15:0] sh_az_low, sh_az_high, sh_el_low, sh_el_high, sh_thr;
  logic        sh_sph;
  logic [31:0] sh_kept;

  longint arctan_turn[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861};

  // Arithmetic shift right, rounding toward minus infinity.
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  // Scale by the CORDIC gain, rounding half up on the magnitude.
  function automatic longint gain_scale(longint v);
    longint unsigned m, hi, lo, p;
    m = (v < 0) ? longint'(-v) : longint'(v);
    hi = m >> 32;
    lo = m & 64'hFFFF_FFFF;
    p = ((hi * 1304065748) << 1) + ((lo * 1304065748 + (64'd1 << 30)) >> 31);
    return (v < 0) ? -longint'(p) : longint'(p);
  endfunction

  // Vectoring: drives y to zero and returns the angle in 2^32 turn units.
  function automatic longint cordic_angle(inout longint x, inout longint y);
    longint a, dx, dy;
    a = 0;
    for (int i = 0; i < 16; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y < 0) begin
        x -= dx; y += dy; a -= arctan_turn[i];
      end else begin
        x += dx; y -= dy; a += arctan_turn[i];
      end
    end
    return a;
  endfunction

  // Rotation of (x, y) by angle a in 2^32 turn units.
  function automatic void cordic_turn(inout longint x, inout longint y, input longint a);
    longint dx, dy;
    for (int i = 0; i < 16; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (a >= 0) begin
        x -= dx; y += dy; a -= arctan_turn[i];
      end else begin
        x += dx; y -= dy; a += arctan_turn[i];
      end
    end
  endfunction

  // Drops the guard bits with rounding and saturates to 32 signed bits.
  function automatic longint drop_guard(longint v);
    longint r;
    r = (v + 128) >>> 8;
    if (r > 64'sd2147483647) return 64'sd2147483647;
    if (r < -64'sd2147483648) return -64'sd2147483648;
    return r;
  endfunction

  // Works out the result of one point under the current settings.
  function automatic point_result_t filter_point(logic [111:0] d);
    point_result_t res;
    longint x, y, z, el, cx, cy, rho, zz, a, bx, by, e, rsc, rr, rs;
    longint unsigned az, r;
    logic [2:0] why;
    bit flip;
    longint el_lo, el_hi;
    if (sh_sph) begin
      flip = 0;
      az = d[15:0];
      el = longint'($signed(d[63:32]));
      if (el > 16384) el = 16384;
      if (el < -16384) el = -16384;
      rs = longint'($signed(d[95:64]));
      if (rs < 0) rs = 0;
      r = rs;
      cx = gain_scale(rs * 256);
      cy = 0;
      cordic_turn(cx, cy, el * 65536);
      rho = cx;
      zz = cy;
      a = longint'(az << 16);
      if (a >= (64'sd1 << 31)) a -= 64'sd1 << 32;
      if (a > (64'sd1 << 30)) begin
        a -= 64'sd1 << 31; flip = 1;
      end else if (a < -(64'sd1 << 30)) begin
        a += 64'sd1 << 31; flip = 1;
      end
      cx = gain_scale(rho);
      cy = 0;
      cordic_turn(cx, cy, a);
      if (flip) begin
        cx = -cx; cy = -cy;
      end
      x = drop_guard(cx);
      y = drop_guard(cy);
      z = drop_guard(zz);
    end else begin
      rho = 0;
      x = longint'($signed(d[31:0]));
      y = longint'($signed(d[63:32]));
      z = longint'($signed(d[95:64]));
      az = 0;
      if (x != 0 || y != 0) begin
        longint b;
        b = 0;
        bx = x * 256;
        by = y * 256;
        if (bx < 0) begin
          bx = -bx; by = -by; b = 64'sd1 << 31;
        end
        a = b + cordic_angle(bx, by);
        rho = gain_scale(bx);
        az = ((longint'(a) + 32768) & 64'hFFFF_FFFF) >> 16;
      end
      el = 0;
      r = 0;
      if (rho != 0 || z != 0) begin
        bx = rho;
        by = z * 256;
        e = cordic_angle(bx, by);
        rsc = gain_scale(bx);
        el = (e + 32768) >>> 16;
        if (el > 16384) el = 16384;
        if (el < -16384) el = -16384;
        rr = (rsc + 128) >>> 8;
        if (rr < 0) rr = 0;
        if (rr > 64'sd4294967295) rr = 64'sd4294967295;
        r = rr;
      end
    end
    // Window tests in order of the reason codes; the first failing one wins.
    el_lo = longint'($signed(sh_el_low));
    el_hi = longint'($signed(sh_el_high));
    why = RsnKept;
    if (r < sh_r_low) why = RsnRLow;
    else if (r > sh_r_high) why = RsnRHigh;
    else if (sh_az_low != sh_az_high && az < sh_az_low) why = RsnAzLow;
    else if (sh_az_low != sh_az_high && az > sh_az_high) why = RsnAzHigh;
    else if (el_lo != el_hi && el < el_lo) why = RsnElLow;
    else if (el_lo != el_hi && el > el_hi) why = RsnElHigh;
    else if (d[111:96] > sh_thr) why = RsnThin;
    if (why == RsnKept) sh_kept = sh_kept + 1;
    res.kept = (why == RsnKept);
    res.reason = why;
    res.x = x[31:0];
    res.y = y[31:0];
    res.z = z[31:0];
    res.az = az[15:0];
    res.el = el[15:0];
    res.r = r[31:0];
    res.total = sh_kept;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: result %0d field %s got %0h expected %0h", $realtime, result_count,
             what, got, want);
    fail_count++;
  endtask

  assign pending_count = expected_results.size();

  // Register writes, point prediction and result comparison.
  always @(posedge clk) begin
    point_result_t want, got;
    if (!rst_n) begin
      sh_r_low <= 0; sh_r_high <= 32'd19660800;
      sh_az_low <= 0; sh_az_high <= 0; sh_el_low <= 0; sh_el_high <= 0;
      sh_thr <= 16'hFFFF; sh_sph <= 0; sh_kept = 0;
      fail_count = 0; result_count <= 0;
      expected_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          RegRLow:  sh_r_low <= cfg_pwdata;
          RegRHigh: sh_r_high <= cfg_pwdata;
          RegAzLow: sh_az_low <= cfg_pwdata[15:0];
          RegAzHi:  sh_az_high <= cfg_pwdata[15:0];
          RegElLow: sh_el_low <= cfg_pwdata[15:0];
          RegElHi:  sh_el_high <= cfg_pwdata[15:0];
          RegThr:   sh_thr <= cfg_pwdata[15:0];
          RegSph:   sh_sph <= cfg_pwdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) expected_results.push_back(filter_point(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata[195:0];
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: result with no point waiting", $realtime);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.kept != want.kept) report_mismatch("kept", got.kept, want.kept);
          if (got.reason != want.reason) report_mismatch("reason", got.reason, want.reason);
          if (got.x != want.x) report_mismatch("x", got.x, want.x);
          if (got.y != want.y) report_mismatch("y", got.y, want.y);
          if (got.z != want.z) report_mismatch("z", got.z, want.z);
          if (got.az != want.az) report_mismatch("az", got.az, want.az);
          if (got.el != want.el) report_mismatch("el", got.el, want.el);
          if (got.r != want.r) report_mismatch("r", got.r, want.r);
          if (got.total != want.total) report_mismatch("kept_total", got.total, want.total);
        end
      end
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives points and register settings into the spherical window point
// filter under random flow control; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_top;
  import swpf_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int Drain = 60;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid, in_tready;
  // [31:0] x_or_az, [63:32] y_or_el, [95:64] z_or_r, [111:96] random_value
  logic [111:0] in_tdata;
  logic         out_tvalid, out_tready;
  // [0] kept, [3:1] reason, [35:4] x, [67:36] y, [99:68] z, [115:100] az,
  // [131:116] el, [163:132] r, [195:164] kept_total
  logic [199:0] out_tdata;
  logic         cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [4:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata, cfg_prdata;
  int           fail_count, pending_count, result_count;
  int           idle_cycles;
  int           points_sent;

  spherical_window_point_filter uut (.*);

  swpf_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls: alternating free-running and stalling stretches.
  initial begin
    int mode;
    out_tready = 0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(5, 60)) begin
        @(posedge clk);
        out_tready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  // Sends one point and waits until it is accepted; random gaps between bursts.
  int burst_left;
  task automatic send_point(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [15:0] rnd);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    burst_left--;
    in_tvalid <= 1;
    in_tdata <= {rnd, c, b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    points_sent++;
    if (burst_left == 0) in_tvalid <= 0;
  endtask

  task automatic wait_idle();
    if (burst_left != 0) in_tvalid <= 0;
    burst_left = 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return $urandom_range(0, 1) ? 0 : $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endcase
  endfunction

  // One random phase of points in the current input mode.
  task automatic random_points(int n, bit sph);
    logic [31:0] a, b, c;
    repeat (n) begin
      if (sph) begin
        a = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 65535);
        b = $urandom_range(0, 7) == 0 ? $urandom : $signed($urandom_range(0, 32768)) - 16384;
        c = rand_coord();
      end else begin
        a = rand_coord(); b = rand_coord(); c = rand_coord();
      end
      send_point(a, b, c, $urandom);
    end
  endtask

  initial begin
    rst_n = 0; in_tvalid = 0; in_tdata = '0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    burst_left = 0; points_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // Directed: origin, axes, extremes and thinning at the reset settings.
    send_point(0, 0, 0, 0);
    send_point(0, 0, 32'h0001_0000, 16'hFFFF);
    send_point(0, 0, 32'hFFFF_0000, 0);
    send_point(32'h0001_0000, 0, 0, 0);
    send_point(32'hFFFF_0000, 32'hFFFF_FFFF, 0, 0);
    send_point(32'hFFFF_0000, 1, 0, 0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hFFFF);
    send_point(32'h0064_0000, 32'h0064_0000, 32'h0000_0000, 16'h1234);
    wait_idle();
    write_reg(RegThr, 32'h0000_8000);
    write_reg(RegAzLow, 32'h0000_1000);
    write_reg(RegAzHi, 32'h0000_9000);
    write_reg(RegElLow, 32'hFFFF_E000);
    write_reg(RegElHi, 32'h0000_2000);
    write_reg(RegRLow, 32'h0001_0000);
    send_point(0, 0, 0, 0);
    send_point(32'h0010_0000, 0, 0, 0);
    send_point(32'h0010_0000, 32'h0010_0000, 0, 16'h8000);
    send_point(32'h0010_0000, 32'h0010_0000, 0, 16'h8001);
    send_point(0, 32'hFFF0_0000, 0, 0);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0010_0000, 0);
    send_point(32'h0001_0000, 32'h0001_0000, 32'hFFF0_0000, 0);
    send_point(32'h0400_0000, 0, 0, 0);
    wait_idle();
    // Spherical directed: wrap, clamp, negative radius.
    write_reg(RegSph, 1);
    write_reg(RegThr, 32'h0000_FFFF);
    write_reg(RegAzLow, 0);
    write_reg(RegAzHi, 0);
    write_reg(RegRLow, 0);
    send_point(32'h0000_FFFF, 0, 32'h0010_0000, 0);
    send_point(32'h0001_8000, 32'h0000_4000, 32'h0010_0000, 0);
    send_point(32'h0000_8000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_point(32'h0000_C000, 32'h8000_0000, 32'h8000_0000, 0);
    send_point(32'h0000_4000, 32'hFFFF_C000, 32'h0001_0000, 0);
    wait_idle();

    // Random phases over several settings, extremes included.
    for (int ph = 0; ph < 10; ph++) begin
      logic [15:0] al, ah;
      write_reg(RegSph, ph[0]);
      write_reg(RegRLow, (ph == 2) ? 32'hFFFF_FFFF : $urandom_range(0, 32'h0008_0000));
      write_reg(RegRHigh, (ph == 3) ? 32'hFFFF_FFFF : (ph == 4) ? 0 : $urandom);
      al = $urandom; ah = $urandom;
      write_reg(RegAzLow, (ph < 2) ? 0 : (al < ah ? al : ah));
      write_reg(RegAzHi, (ph < 2) ? 0 : (ph == 5) ? 16'hFFFF : (al < ah ? ah : al));
      write_reg(RegElLow, (ph == 6) ? 32'hFFFF_C000 : $signed($urandom_range(0, 16384)) - 16384);
      write_reg(RegElHi, (ph == 6) ? 32'h0000_4000 : $urandom_range(0, 16384));
      write_reg(RegThr, (ph == 7) ? 0 : (ph == 8) ? 16'hFFFF : $urandom);
      random_points(100, ph[0]);
      wait_idle();
    end

    $display("Covered %0d points with %0d results over Cartesian and spherical input,",
             points_sent, result_count);
    $display("and window, thinning and saturation settings from edge to edge.");
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
